// ----- hw/rtl/cevq_pkg.sv -----
// cevq_pkg: shared types and codes for the coalescing event queue.
// Used by cevq_front, cevq_back and coalescing_event_queue_core.
`timescale 1ns / 1ps

package cevq_pkg;

    localparam int TYPE_W    = 8;
    localparam int TARGET_W  = 16;
    localparam int PAYLOAD_W = 32;
    localparam int REQ_W     = 2;
    localparam int KIND_W    = 2;
    localparam int DATA_W    = TYPE_W + TARGET_W + PAYLOAD_W;

    // request codes on the input tuser
    localparam logic [REQ_W-1:0] REQ_PLAIN  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_UNIQUE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FLUSH  = 2'd2;

    // result kinds on the output tuser
    localparam logic [KIND_W-1:0] KIND_APPEND   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COALESCE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROP     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FLUSH    = 2'd3;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_UNIQUE,
        OP_FLUSH
    } cmd_op_t;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic [TARGET_W-1:0]  target;
        logic [TYPE_W-1:0]    etype;
    } entry_t;

    typedef struct packed {
        cmd_op_t op;
        entry_t  entry;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPEND,
        ST_COAL,
        ST_FLUSH
    } state_t;

endpackage

// ----- hw/rtl/cevq_front.sv -----
// cevq_front: accepts input items, decodes the request and queues commands.
// Depends on cevq_pkg.
`timescale 1ns / 1ps

module cevq_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [cevq_pkg::DATA_W-1:0] s_tdata,   // event_type, target_id, payload_handle
    input  logic [cevq_pkg::REQ_W-1:0]  s_tuser,   // req_type
    output logic                        cmd_valid,
    input  logic                        cmd_ready,
    output cevq_pkg::cmd_t              cmd
);

    localparam int FIFO_DEPTH = 2;

    cevq_pkg::cmd_t fifo_reg [FIFO_DEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;
    logic           push, pop, known;
    cevq_pkg::cmd_op_t op;

    // unused request code is dropped here
    always_comb begin
        known = 1'b1;
        op    = cevq_pkg::OP_PUSH;
        unique case (s_tuser)
            cevq_pkg::REQ_PLAIN:  op = cevq_pkg::OP_PUSH;
            cevq_pkg::REQ_UNIQUE: op = cevq_pkg::OP_UNIQUE;
            cevq_pkg::REQ_FLUSH:  op = cevq_pkg::OP_FLUSH;
            default:              known = 1'b0;
        endcase
    end

    assign s_tready  = (fill_reg != 2'(FIFO_DEPTH));
    assign push      = s_tvalid && s_tready && known;
    assign cmd_valid = (fill_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg].op    <= op;
            fifo_reg[wr_ptr_reg].entry <= s_tdata;
        end
    end

endmodule

// ----- hw/rtl/cevq_back.sv -----
// cevq_back: entry store, scan/append/flush sequencer and output register.
// Depends on cevq_pkg.
`timescale 1ns / 1ps

module cevq_back #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  cevq_pkg::cmd_t               cmd,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [cevq_pkg::DATA_W-1:0]  m_tdata,
    output logic [cevq_pkg::KIND_W-1:0]  m_tuser,
    output logic                         m_tlast
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cevq_pkg::entry_t mem [QUEUE_DEPTH];
    cevq_pkg::entry_t rd_data_reg;

    cevq_pkg::state_t state_reg, state_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    cevq_pkg::cmd_t   cmd_reg, cmd_next;

    logic                        out_valid_reg;
    logic [cevq_pkg::KIND_W-1:0] out_kind_reg;
    cevq_pkg::entry_t            out_entry_reg;
    logic                        out_last_reg;

    logic [PTR_W-1:0]            rd_addr, wr_addr;
    logic                        wr_en;
    logic                        emit, emit_last;
    logic [cevq_pkg::KIND_W-1:0] emit_kind;
    cevq_pkg::entry_t            emit_entry;
    logic                        out_free;
    logic [CNT_W-1:0]            cnt_m1;
    logic                        full;

    assign out_free = !out_valid_reg || m_tready;
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cevq_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        cmd_reg <= cmd_next;
    end

    always_comb begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        count_next = count_reg;
        cmd_next   = cmd_reg;
        rd_addr    = ptr_reg;
        wr_en      = 1'b0;
        wr_addr    = ptr_reg;
        emit       = 1'b0;
        emit_kind  = cevq_pkg::KIND_APPEND;
        emit_entry = '0;
        emit_last  = 1'b1;
        cmd_ready  = 1'b0;
        unique case (state_reg)
            cevq_pkg::ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    cmd_next = cmd;
                    unique case (cmd.op)
                        cevq_pkg::OP_PUSH: state_next = cevq_pkg::ST_APPEND;
                        cevq_pkg::OP_UNIQUE: begin
                            if (count_reg == '0) begin
                                state_next = cevq_pkg::ST_APPEND;
                            end else begin
                                rd_addr    = cnt_m1[PTR_W-1:0];
                                ptr_next   = cnt_m1[PTR_W-1:0];
                                state_next = cevq_pkg::ST_SCAN;
                            end
                        end
                        cevq_pkg::OP_FLUSH: begin
                            if (count_reg != '0) begin
                                rd_addr    = '0;
                                ptr_next   = '0;
                                state_next = cevq_pkg::ST_FLUSH;
                            end
                        end
                        default: state_next = cevq_pkg::ST_IDLE;
                    endcase
                end
            end
            cevq_pkg::ST_SCAN: begin
                // newest to oldest; first target match decides
                if (rd_data_reg.target == cmd_reg.entry.target) begin
                    state_next = (rd_data_reg.etype == cmd_reg.entry.etype) ?
                                 cevq_pkg::ST_COAL : cevq_pkg::ST_APPEND;
                end else if (ptr_reg == '0) begin
                    state_next = cevq_pkg::ST_APPEND;
                end else begin
                    ptr_next = ptr_reg - PTR_W'(1);
                    rd_addr  = ptr_reg - PTR_W'(1);
                end
            end
            cevq_pkg::ST_APPEND: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (full) begin
                        emit_kind = cevq_pkg::KIND_DROP;
                    end else begin
                        emit_kind  = cevq_pkg::KIND_APPEND;
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[PTR_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = cevq_pkg::ST_IDLE;
                end
            end
            cevq_pkg::ST_COAL: begin
                // type and target already equal, so the whole entry is rewritten
                if (out_free) begin
                    emit       = 1'b1;
                    emit_kind  = cevq_pkg::KIND_COALESCE;
                    wr_en      = 1'b1;
                    state_next = cevq_pkg::ST_IDLE;
                end
            end
            cevq_pkg::ST_FLUSH: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_kind  = cevq_pkg::KIND_FLUSH;
                    emit_entry = rd_data_reg;
                    emit_last  = (ptr_reg == cnt_m1[PTR_W-1:0]);
                    if (emit_last) begin
                        count_next = '0;
                        state_next = cevq_pkg::ST_IDLE;
                    end else begin
                        ptr_next = ptr_reg + PTR_W'(1);
                        rd_addr  = ptr_reg + PTR_W'(1);
                    end
                end
            end
            default: state_next = cevq_pkg::ST_IDLE;
        endcase
    end

    // store with one write port and one read port, registered read every cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= cmd_reg.entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_kind_reg  <= emit_kind;
            out_entry_reg <= emit_entry;
            out_last_reg  <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_entry_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above depth");

    a_drop_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && emit_kind == cevq_pkg::KIND_DROP) |-> full)
        else $error("drop reported with room left");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && emit_kind == cevq_pkg::KIND_APPEND) |=>
        count_reg == $past(count_reg) + CNT_W'(1))
        else $error("append did not grow the queue");

    a_flush_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && emit_kind == cevq_pkg::KIND_FLUSH && emit_last) |=>
        count_reg == '0)
        else $error("flush left entries behind");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cevq_pkg::ST_SCAN || state_reg == cevq_pkg::ST_FLUSH) |->
        (CNT_W'(ptr_reg) < count_reg))
        else $error("pointer past stored entries");
`endif

endmodule

// ----- hw/rtl/coalescing_event_queue_core.sv -----
// Coalescing event queue: a bounded FIFO of events with in-place coalescing.
// Plain push: command queue, IDLE, APPEND, output register. Unique push: a SCAN of
// entries newest-first through the registered-read store before APPEND or COAL.
// Flush: after IDLE, one entry per cycle while the output is not stalled.
// aresetn (sync, active low) empties the queue; the store itself is not cleared.
// Two-command queue between front and back absorbs items while a scan runs.
`timescale 1ns / 1ps

module coalescing_event_queue_core #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input items
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [cevq_pkg::DATA_W-1:0]  s_tdata,   // event_type, target_id, payload_handle
    input  logic [cevq_pkg::REQ_W-1:0]   s_tuser,   // req_type
    // result items
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [cevq_pkg::DATA_W-1:0]  m_tdata,   // out_event_type, out_target_id,
                                                    // out_payload_handle
    output logic [cevq_pkg::KIND_W-1:0]  m_tuser,   // result_kind
    output logic                         m_tlast    // last_of_run
);

    logic           cmd_valid;
    logic           cmd_ready;
    cevq_pkg::cmd_t cmd;

    // front: decode request, drop unused code, queue command
    cevq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // back: entry store, scan, append, flush and the output register
    cevq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
